>>> hw/rtl/safh_pkg.sv
// safh_pkg: shared constants for the swept box first-hit search
// register indexes, contact sign codes and the window width
// no dependencies
package safh_pkg;

	localparam int WINDOW_BITS  = 16;
	localparam int REG_IDX_BITS = 3;

	localparam logic [REG_IDX_BITS-1:0] REG_MOVER_MIN_X = 3'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_MOVER_MAX_X = 3'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_MOVER_MIN_Y = 3'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_MOVER_MAX_Y = 3'd3;
	localparam logic [REG_IDX_BITS-1:0] REG_VEL_X       = 3'd4;
	localparam logic [REG_IDX_BITS-1:0] REG_VEL_Y       = 3'd5;
	localparam logic [REG_IDX_BITS-1:0] REG_WINDOW_MS   = 3'd6;

	// contact face codes, two bit two's complement
	localparam logic [1:0] SIGN_NONE = 2'b00;
	localparam logic [1:0] SIGN_POS  = 2'b01;
	localparam logic [1:0] SIGN_NEG  = 2'b11;

endpackage

>>> hw/rtl/swept_aabb_first_hit.sv
// swept_aabb_first_hit: earliest-hit search of a moving box against streamed obstacles
// one shared multiplier under a small sequencer does all rational compares
// depends on safh_pkg
//
// Configure the mover box, velocity and window through the write port while idle, then
// stream obstacles. Each obstacle passes the idle cycle, one axis evaluation, nine
// multiplier steps and one finish, or goes to the finish early: from the evaluation when
// an axis misses outright or the request is empty, after the exit compare when the exit
// comes before the entry, and after the window compare when the entry falls outside the
// window. The nine steps are the serial passes through the single multiplier that
// cross-multiplies entry, exit, window and best-so-far times. The block takes no new
// obstacle until the current one finishes. On an item marked last, one result is
// produced and the search state clears; a result waiting on res_stall does not block
// the next obstacle, only the next last request, which holds in the finish step until
// the result is taken. Times come out as exact rationals time_num / time_den.
module swept_aabb_first_hit
	import safh_pkg::*;
#(
	parameter int COORD_BITS = 16,
	parameter int ID_BITS    = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [REG_IDX_BITS-1:0]            cfg_idx,
	input  logic [((COORD_BITS > WINDOW_BITS) ? COORD_BITS : WINDOW_BITS)-1:0] cfg_data,
	input  logic                               obs_valid,
	output logic                               obs_stall,
	input  logic                               has_obstacle,
	input  logic [ID_BITS-1:0]                 obs_id,
	input  logic signed [COORD_BITS-1:0]       obs_x,
	input  logic signed [COORD_BITS-1:0]       obs_y,
	input  logic [COORD_BITS-2:0]              obs_w,
	input  logic [COORD_BITS-2:0]              obs_h,
	input  logic                               last,
	output logic                               res_valid,
	input  logic                               res_stall,
	output logic                               hit,
	output logic [ID_BITS-1:0]                 hit_id,
	output logic [COORD_BITS:0]                time_num,
	output logic [COORD_BITS-2:0]              time_den,
	output logic                               face_axis,
	output logic signed [1:0]                  face_sign
);

	localparam int CB = COORD_BITS;
	localparam int DW = CB - 1;
	localparam int NW = (CB + 1 > WINDOW_BITS) ? CB + 1 : WINDOW_BITS;
	localparam int EW = CB + 3;
	localparam int PW = NW + DW;
	localparam logic [DW-1:0] DMAX = {DW{1'b1}};
	localparam logic [DW-1:0] DONE = DW'(1);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_EVAL = 4'd1;
	localparam logic [3:0] ST_M0   = 4'd2;
	localparam logic [3:0] ST_M1   = 4'd3;
	localparam logic [3:0] ST_M2   = 4'd4;
	localparam logic [3:0] ST_M3   = 4'd5;
	localparam logic [3:0] ST_M4   = 4'd6;
	localparam logic [3:0] ST_M5   = 4'd7;
	localparam logic [3:0] ST_M6   = 4'd8;
	localparam logic [3:0] ST_M7   = 4'd9;
	localparam logic [3:0] ST_M8   = 4'd10;
	localparam logic [3:0] ST_FIN  = 4'd11;

	typedef struct packed {
		logic          ok;
		logic          unb;
		logic [NW-1:0] en;
		logic [NW-1:0] xn;
		logic [DW-1:0] den;
		logic [1:0]    sign;
	} axis_t;

	function automatic axis_t axis_eval(
		input logic signed [CB-1:0] mmin,
		input logic signed [CB-1:0] mmax,
		input logic signed [CB-1:0] omin,
		input logic [CB-2:0]        len,
		input logic signed [CB-1:0] v
	);
		logic signed [EW-1:0] lo, hi, mn, mx, ent, ext;
		logic [CB-1:0] mag;
		axis_t r;
		lo = EW'(omin);
		hi = lo + EW'($signed({1'b0, len}));
		mn = EW'(mmin);
		mx = EW'(mmax);
		r.ok = 1'b0;
		r.unb = 1'b1;
		r.en = '0;
		r.xn = '0;
		r.den = DONE;
		r.sign = SIGN_NONE;
		ent = '0;
		ext = '0;
		mag = '0;
		if (v == '0) begin
			r.ok = !(mx <= lo || mn >= hi);
		end else begin
			if (!v[CB-1]) begin
				ent = lo - mx;
				ext = hi - mn;
				mag = CB'(v);
				r.sign = SIGN_NEG;
			end else begin
				ent = mn - hi;
				ext = mx - lo;
				mag = CB'(-v);
				r.sign = SIGN_POS;
			end
			r.ok = (ext > 0);
			r.unb = 1'b0;
			r.den = (mag > {1'b0, DMAX}) ? DMAX : mag[DW-1:0];
			r.en = (ent > 0) ? NW'(ent) : '0;
			r.xn = NW'(ext);
		end
		return r;
	endfunction

	// configuration
	logic signed [CB-1:0] mmin_x_q, mmax_x_q, mmin_y_q, mmax_y_q, vel_x_q, vel_y_q;
	logic [WINDOW_BITS-1:0] win_q;

	// captured request
	logic [ID_BITS-1:0]   id_q;
	logic signed [CB-1:0] ox_q, oy_q;
	logic [CB-2:0]        ow_q, oh_q;
	logic                 has_q, last_q;

	logic [3:0] state_q;
	axis_t ax_q, ay_q, ax_c, ay_c;

	// chosen entry axis and exit term
	logic [NW-1:0] g_en_q;
	logic [DW-1:0] g_den_q;
	logic [1:0]    g_sign_q;
	logic          g_axis_q;
	logic [NW-1:0] ex_xn_q;
	logic [DW-1:0] ex_den_q;
	logic          ex_unb_q;

	// search state
	logic          found_q;
	logic [ID_BITS-1:0] best_id_q;
	logic [CB:0]   best_num_q;
	logic [DW-1:0] best_den_q;
	logic          best_axis_q;
	logic [1:0]    best_sign_q;

	// result register
	logic          res_valid_q;
	logic          hit_q;
	logic [ID_BITS-1:0] hit_id_q;
	logic [CB:0]   num_q;
	logic [DW-1:0] den_q;
	logic          axis_q;
	logic [1:0]    sign_q;
	logic          res_load;

	logic [NW-1:0] mul_a;
	logic [DW-1:0] mul_b;
	logic [PW-1:0] prod, tmp_q;
	logic          less, same;

	assign ax_c = axis_eval(mmin_x_q, mmax_x_q, ox_q, ow_q, vel_x_q);
	assign ay_c = axis_eval(mmin_y_q, mmax_y_q, oy_q, oh_q, vel_y_q);

	always_comb begin
		mul_a = '0;
		mul_b = DONE;
		case (state_q)
			ST_M0: begin mul_a = ay_q.en;  mul_b = ax_q.den; end
			ST_M1: begin mul_a = ax_q.en;  mul_b = ay_q.den; end
			ST_M2: begin mul_a = ax_q.xn;  mul_b = ay_q.den; end
			ST_M3: begin mul_a = ay_q.xn;  mul_b = ax_q.den; end
			ST_M4: begin mul_a = ex_xn_q;  mul_b = g_den_q;  end
			ST_M5: begin mul_a = g_en_q;   mul_b = ex_den_q; end
			ST_M6: begin mul_a = NW'(win_q); mul_b = g_den_q; end
			ST_M7: begin mul_a = g_en_q;   mul_b = best_den_q; end
			ST_M8: begin mul_a = NW'(best_num_q); mul_b = g_den_q; end
			default: begin mul_a = '0; mul_b = DONE; end
		endcase
	end

	assign prod = PW'(mul_a) * PW'(mul_b);
	assign less = (tmp_q < prod);
	assign same = (tmp_q == prod);

	assign obs_stall = (state_q != ST_IDLE);

	// a last request reports once the result register is free or being taken
	assign res_load = (state_q == ST_FIN) && last_q && (!res_valid_q || !res_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mmin_x_q <= '0;
			mmax_x_q <= '0;
			mmin_y_q <= '0;
			mmax_y_q <= '0;
			vel_x_q <= '0;
			vel_y_q <= '0;
			win_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_MOVER_MIN_X: mmin_x_q <= cfg_data[CB-1:0];
				REG_MOVER_MAX_X: mmax_x_q <= cfg_data[CB-1:0];
				REG_MOVER_MIN_Y: mmin_y_q <= cfg_data[CB-1:0];
				REG_MOVER_MAX_Y: mmax_y_q <= cfg_data[CB-1:0];
				REG_VEL_X:       vel_x_q <= cfg_data[CB-1:0];
				REG_VEL_Y:       vel_y_q <= cfg_data[CB-1:0];
				REG_WINDOW_MS:   win_q <= cfg_data[WINDOW_BITS-1:0];
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && obs_valid) begin
			id_q <= obs_id;
			ox_q <= obs_x;
			oy_q <= obs_y;
			ow_q <= obs_w;
			oh_q <= obs_h;
		end
		if (state_q == ST_EVAL) begin
			ax_q <= ax_c;
			ay_q <= ay_c;
		end
		if (state_q == ST_M0 || state_q == ST_M2 || state_q == ST_M4 || state_q == ST_M7) begin
			tmp_q <= prod;
		end
		if (state_q == ST_M1) begin
			if (less || (same && vel_x_q != '0)) begin
				g_en_q <= ax_q.en;
				g_den_q <= ax_q.den;
				g_sign_q <= ax_q.sign;
				g_axis_q <= 1'b0;
			end else begin
				g_en_q <= ay_q.en;
				g_den_q <= ay_q.den;
				g_sign_q <= ay_q.sign;
				g_axis_q <= 1'b1;
			end
		end
		if (state_q == ST_M3) begin
			if (ax_q.unb || (!ay_q.unb && !less)) begin
				ex_xn_q <= ay_q.xn;
				ex_den_q <= ay_q.den;
				ex_unb_q <= ay_q.unb;
			end else begin
				ex_xn_q <= ax_q.xn;
				ex_den_q <= ax_q.den;
				ex_unb_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			has_q <= 1'b0;
			last_q <= 1'b0;
			found_q <= 1'b0;
			best_id_q <= '0;
			best_num_q <= '0;
			best_den_q <= DONE;
			best_axis_q <= 1'b0;
			best_sign_q <= SIGN_NONE;
			res_valid_q <= 1'b0;
			hit_q <= 1'b0;
			hit_id_q <= '0;
			num_q <= '0;
			den_q <= DONE;
			axis_q <= 1'b0;
			sign_q <= SIGN_NONE;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (obs_valid) begin
						has_q <= has_obstacle;
						last_q <= last;
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					state_q <= (has_q && ax_c.ok && ay_c.ok) ? ST_M0 : ST_FIN;
				end
				ST_M0: state_q <= ST_M1;
				ST_M1: state_q <= ST_M2;
				ST_M2: state_q <= ST_M3;
				ST_M3: state_q <= ST_M4;
				ST_M4: state_q <= ST_M5;
				ST_M5: begin
					// exit before entry is a miss, touching still hits
					state_q <= (!ex_unb_q && less) ? ST_FIN : ST_M6;
				end
				ST_M6: begin
					state_q <= (PW'(g_en_q) >= prod) ? ST_FIN : ST_M7;
				end
				ST_M7: state_q <= ST_M8;
				ST_M8: begin
					if (!found_q || less || (same && id_q < best_id_q)) begin
						found_q <= 1'b1;
						best_id_q <= id_q;
						best_num_q <= g_en_q[CB:0];
						best_den_q <= g_den_q;
						best_axis_q <= g_axis_q;
						best_sign_q <= g_sign_q;
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (res_load) begin
						hit_q <= found_q;
						hit_id_q <= best_id_q;
						num_q <= best_num_q;
						den_q <= best_den_q;
						axis_q <= best_axis_q;
						sign_q <= best_sign_q;
						found_q <= 1'b0;
						best_id_q <= '0;
						best_num_q <= '0;
						best_den_q <= DONE;
						best_axis_q <= 1'b0;
						best_sign_q <= SIGN_NONE;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign hit = hit_q;
	assign hit_id = hit_id_q;
	assign time_num = num_q;
	assign time_den = den_q;
	assign face_axis = axis_q;
	assign face_sign = $signed(sign_q);

`ifndef SYNTHESIS
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		best_den_q != '0) else $error("best denominator is zero");
	a_res_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(last_q) && $past(state_q) == ST_FIN)
		else $error("result without a last request");
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_stall |=> res_valid_q && $stable(hit_id_q) && $stable(num_q))
		else $error("stalled result changed");
	a_nohit_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!found_q |-> best_num_q == '0 && best_den_q == DONE && best_sign_q == SIGN_NONE)
		else $error("search state not clear without a hit");
`endif

endmodule

>>> sim/swept_aabb_first_hit_tb.sv
// swept_aabb_first_hit_tb: self-checking bench for the swept box first-hit search
// predicts each list's earliest hit with exact rational compares and checks every result
// depends on safh_pkg and swept_aabb_first_hit
module swept_aabb_first_hit_tb;
	import safh_pkg::*;

	localparam int CB = 16;
	localparam int IB = 16;
	localparam longint CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic          has;
		logic [IB-1:0] id;
		logic [CB-1:0] x;
		logic [CB-1:0] y;
		logic [CB-2:0] w;
		logic [CB-2:0] h;
		logic          lst;
	} obstacle_t;

	typedef struct packed {
		logic          hit;
		logic [IB-1:0] id;
		logic [CB:0]   num;
		logic [CB-2:0] den;
		logic          axis;
		logic [1:0]    sign;
	} first_hit_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [REG_IDX_BITS-1:0] cfg_idx = REG_MOVER_MIN_X;
	logic [15:0] cfg_data = '0;
	logic obs_valid = 0;
	logic obs_stall;
	logic has_obstacle = 0;
	logic [IB-1:0] obs_id = '0;
	logic signed [CB-1:0] obs_x = '0, obs_y = '0;
	logic [CB-2:0] obs_w = '0, obs_h = '0;
	logic last = 0;
	logic res_valid;
	logic res_stall = 0;
	logic hit;
	logic [IB-1:0] hit_id;
	logic [CB:0] time_num;
	logic [CB-2:0] time_den;
	logic face_axis;
	logic signed [1:0] face_sign;

	swept_aabb_first_hit #(.COORD_BITS(CB), .ID_BITS(IB)) uut (.*);

	initial forever #5 clk = ~clk;

	// mover setup mirrored for prediction
	longint m_minx, m_maxx, m_miny, m_maxy, vx, vy, win;
	// running search state
	bit s_found;
	longint s_id, s_num, s_den, s_axis;
	logic [1:0] s_sign;

	obstacle_t pending_obstacles[$];
	first_hit_t expected_hits[$];
	int send_idle_pct = 0, recv_idle_pct = 0;
	bit recv_hold = 0;
	bit send_pause = 0;
	int errors = 0;
	longint cycles = 0;

	function automatic int rcmp(longint a, longint b, longint c, longint d);
		longint l, r;
		l = a * d;
		r = c * b;
		return (l < r) ? -1 : (l > r) ? 1 : 0;
	endfunction

	// per-axis swept interval; returns 0 on a miss
	function automatic bit sweep_axis(longint mn, longint mx, longint omn, longint omx,
			longint v, output longint en, output longint ed, output longint xn,
			output longint xd, output bit unb, output logic [1:0] sg);
		longint e, x, d;
		en = 0; ed = 1; xn = 0; xd = 1; unb = 1; sg = SIGN_NONE;
		if (v == 0)
			return !(mx <= omn || mn >= omx);
		if (v > 0) begin
			e = omn - mx; x = omx - mn; d = v; sg = SIGN_NEG;
		end else begin
			e = mn - omx; x = mx - omn; d = -v; sg = SIGN_POS;
		end
		if (x <= 0)
			return 0;
		if (d > 32767)
			d = 32767;
		en = (e > 0) ? e : 0;
		ed = d; xn = x; xd = d; unb = 0;
		return 1;
	endfunction

	function automatic void clear_search();
		s_found = 0; s_id = 0; s_num = 0; s_den = 1; s_axis = 0; s_sign = SIGN_NONE;
	endfunction

	function automatic void predict_obstacle(obstacle_t o);
		longint ox, oy, aen, aed, axn, axd, ben, bed, bxn, bxd, gn, gd, en_x, ed_x;
		bit aun, bun, gx, better;
		logic [1:0] as, bs;
		first_hit_t r;
		if (o.has) begin
			ox = $signed(o.x);
			oy = $signed(o.y);
			if (sweep_axis(m_minx, m_maxx, ox, ox + o.w, vx, aen, aed, axn, axd, aun, as) &&
					sweep_axis(m_miny, m_maxy, oy, oy + o.h, vy, ben, bed, bxn, bxd,
					bun, bs)) begin
				gx = (rcmp(ben, bed, aen, aed) < 0) || (rcmp(ben, bed, aen, aed) == 0
					&& vx != 0);
				gn = gx ? aen : ben;
				gd = gx ? aed : bed;
				if (aun) begin
					en_x = bxn; ed_x = bxd;
				end else if (bun || rcmp(axn, axd, bxn, bxd) < 0) begin
					en_x = axn; ed_x = axd;
				end else begin
					en_x = bxn; ed_x = bxd;
				end
				if (!(aun && bun) && rcmp(en_x, ed_x, gn, gd) < 0)
					;
				else if (gn >= win * gd)
					;
				else begin
					better = !s_found || rcmp(gn, gd, s_num, s_den) < 0 ||
						(rcmp(gn, gd, s_num, s_den) == 0 && o.id < s_id);
					if (better) begin
						s_found = 1; s_id = o.id; s_num = gn; s_den = gd;
						s_axis = gx ? 0 : 1; s_sign = gx ? as : bs;
					end
				end
			end
		end
		if (o.lst) begin
			r.hit = s_found; r.id = IB'(s_id); r.num = (CB+1)'(s_num);
			r.den = (CB-1)'(s_den); r.axis = s_axis[0]; r.sign = s_sign;
			expected_hits.push_back(r);
			clear_search();
		end
	endfunction

	// driver
	always @(posedge clk) begin
		if (obs_valid && !obs_stall) begin
			predict_obstacle({has_obstacle, obs_id, obs_x, obs_y, obs_w, obs_h, last});
		end
		if (!obs_valid || !obs_stall) begin
			if (pending_obstacles.size() > 0 && !send_pause &&
					$urandom_range(99) >= send_idle_pct) begin
				obstacle_t o;
				o = pending_obstacles.pop_front();
				obs_valid <= 1;
				{has_obstacle, obs_id, obs_x, obs_y, obs_w, obs_h, last} <= o;
			end else
				obs_valid <= 0;
		end
	end

	// receiver stall and result checking
	always @(posedge clk) begin
		first_hit_t e;
		if (arst_n) cycles <= cycles + 1;
		if (res_valid && !res_stall) begin
			if (expected_hits.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result id %0d", hit_id);
			end else begin
				e = expected_hits.pop_front();
				if ({hit, hit_id, time_num, time_den, face_axis, face_sign} !== e) begin
					errors++;
					if (errors <= 10)
						$display({"mismatch exp hit %0d id %0d t %0d/%0d ax %0d sg %0d,",
							" got %0d %0d %0d/%0d %0d %0d"},
							e.hit, e.id, e.num, e.den, e.axis, $signed(e.sign), hit,
							hit_id, time_num, time_den, face_axis, face_sign);
				end
			end
		end
		res_stall <= recv_hold || ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) if (cycles > CYCLE_LIMIT) begin
		$display("swept_aabb_first_hit_tb NOT OK");
		$finish;
	end

	task automatic write_reg(logic [REG_IDX_BITS-1:0] idx, logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1; cfg_idx <= idx; cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		case (idx)
			REG_MOVER_MIN_X: m_minx = $signed(val);
			REG_MOVER_MAX_X: m_maxx = $signed(val);
			REG_MOVER_MIN_Y: m_miny = $signed(val);
			REG_MOVER_MAX_Y: m_maxy = $signed(val);
			REG_VEL_X: vx = $signed(val);
			REG_VEL_Y: vy = $signed(val);
			default: win = val;
		endcase
	endtask

	task automatic drain();
		while (pending_obstacles.size() > 0 || obs_valid || expected_hits.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [15:0] rnd_coord(bit wide);
		return wide ? 16'($urandom) : 16'($signed($urandom_range(80)) - 40);
	endfunction

	task automatic setup_mover(bit wide);
		logic [15:0] a, b;
		a = rnd_coord(wide); b = 16'(a + $urandom_range(20));
		if ($urandom_range(15) == 0) b = a - 16'd3;
		write_reg(REG_MOVER_MIN_X, a); write_reg(REG_MOVER_MAX_X, b);
		a = rnd_coord(wide); b = 16'(a + $urandom_range(20));
		write_reg(REG_MOVER_MIN_Y, a); write_reg(REG_MOVER_MAX_Y, b);
		write_reg(REG_VEL_X, ($urandom_range(3) == 0) ? 16'd0 :
			wide ? 16'($urandom) : 16'($signed($urandom_range(20)) - 10));
		write_reg(REG_VEL_Y, ($urandom_range(3) == 0) ? 16'd0 :
			wide ? 16'($urandom) : 16'($signed($urandom_range(20)) - 10));
		write_reg(REG_WINDOW_MS, ($urandom_range(9) == 0) ? 16'd0 :
			wide ? 16'($urandom) : 16'($urandom_range(1, 40)));
	endtask

	task automatic add_obs(bit has, int id, int x, int y, int w, int h, bit lst);
		obstacle_t o;
		o.has = has; o.id = IB'(id); o.x = CB'(x); o.y = CB'(y);
		o.w = (CB-1)'(w); o.h = (CB-1)'(h); o.lst = lst;
		pending_obstacles.push_back(o);
	endtask

	task automatic random_lists(int n_items, bit wide);
		int k;
		k = 0;
		while (k < n_items) begin
			int len;
			len = $urandom_range(1, 6);
			for (int j = 0; j < len; j++) begin
				obstacle_t o;
				o.has = ($urandom_range(9) != 0);
				o.id = ($urandom_range(3) == 0) ? 16'($urandom_range(3)) : 16'($urandom);
				o.x = rnd_coord(wide || $urandom_range(7) == 0);
				o.y = rnd_coord(wide || $urandom_range(7) == 0);
				o.w = wide ? 15'($urandom) : 15'($urandom_range(30));
				o.h = wide ? 15'($urandom) : 15'($urandom_range(30));
				o.lst = (j == len - 1);
				pending_obstacles.push_back(o);
				k++;
			end
		end
	endtask

	initial begin
		m_minx = 0; m_maxx = 0; m_miny = 0; m_maxy = 0; vx = 0; vy = 0; win = 0;
		clear_search();
		repeat (3) @(posedge clk);
		arst_n <= 1;

		// directed: moving right into a box, ties on id, window edge
		write_reg(REG_MOVER_MIN_X, 0); write_reg(REG_MOVER_MAX_X, 4);
		write_reg(REG_MOVER_MIN_Y, 0); write_reg(REG_MOVER_MAX_Y, 4);
		write_reg(REG_VEL_X, 2); write_reg(REG_VEL_Y, 0);
		write_reg(REG_WINDOW_MS, 10);
		add_obs(1, 7, 10, 0, 4, 4, 0);
		add_obs(1, 3, 10, 1, 4, 4, 0);
		add_obs(1, 9, -10, 0, 4, 4, 1);   // behind: moving away
		add_obs(1, 1, 24, 0, 4, 4, 1);    // entry exactly at window
		add_obs(1, 1, 23, 0, 2, 4, 1);
		add_obs(1, 2, 4, 4, 3, 3, 1);     // touching corner
		add_obs(1, 2, 5, 10, 3, 3, 1);    // off on the resting axis
		add_obs(0, 5, 5, 0, 3, 3, 1);     // empty item reports
		add_obs(1, 16'hffff, 16'h7fff, 16'h8000, 15'h7fff, 15'h7fff, 1);
		drain();
		// both at rest, overlapping, and extreme negative velocity
		write_reg(REG_VEL_X, 0);
		add_obs(1, 4, 1, 1, 1, 1, 1);
		add_obs(1, 4, 8, 1, 1, 1, 1);
		drain();
		write_reg(REG_VEL_X, 16'h8000); write_reg(REG_VEL_Y, 16'h8000);
		write_reg(REG_WINDOW_MS, 16'hffff);
		add_obs(1, 0, -20, -20, 5, 5, 0);
		add_obs(1, 1, -40, -10, 5, 5, 1);
		add_obs(1, 0, 16'h8000, 16'h8000, 0, 0, 1);
		drain();
		write_reg(REG_WINDOW_MS, 0);
		add_obs(1, 0, -20, -20, 5, 5, 1);
		drain();
		write_reg(REG_MOVER_MIN_X, 16'h7fff); write_reg(REG_MOVER_MAX_X, 16'h8000);
		write_reg(REG_MOVER_MIN_Y, 16'h8000); write_reg(REG_MOVER_MAX_Y, 16'h7fff);
		write_reg(REG_VEL_X, 16'h7fff); write_reg(REG_VEL_Y, 16'h8001);
		write_reg(REG_WINDOW_MS, 16'hffff);
		add_obs(1, 5, 0, 0, 15'h7fff, 15'h7fff, 1);
		drain();

		// random phases with changing idling
		for (int ph = 0; ph < 12; ph++) begin
			send_idle_pct = (ph < 4) ? 8 : (ph < 8) ? 46 : 0;
			recv_idle_pct = (ph < 4) ? 46 : (ph < 8) ? 8 : 0;
			setup_mover(ph % 3 == 2);
			random_lists(42, ph % 3 == 2);
			if (ph == 5) begin
				// long receiver hold while obstacles keep coming
				recv_hold = 1;
				repeat (300) @(posedge clk);
				recv_hold = 0;
			end
			if (ph == 9) begin
				while (pending_obstacles.size() > 20) @(posedge clk);
				send_pause = 1;
				while (obs_valid || expected_hits.size() > 0) @(posedge clk);
				send_pause = 0;
			end
			drain();
		end

		if (errors == 0)
			$display("swept_aabb_first_hit_tb OK");
		else
			$display("swept_aabb_first_hit_tb NOT OK");
		$finish;
	end
endmodule
